/* src/sof_pkg.sv */
// Stereo output formatter: shared types, register codes and field widths.
// No dependencies; every other file of the block uses it by scoped names.
package sof_pkg;

  localparam int COLOR_W    = 8;
  localparam int IDX_W      = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int TILE_W     = 12;
  localparam int TILE_CNT_W = 11;
  localparam int TILE_LIMIT = 2048;

  localparam logic [COLOR_W-1:0]    ALPHA_OPAQUE  = 8'hFF;
  localparam logic [1:0]            RST_MODE      = 2'd0;
  localparam logic [CFG_DATA_W-1:0] RST_TILE_SIZE = 12'd8;
  localparam logic [CFG_DATA_W-1:0] RST_WIDTH     = 12'd1920;
  localparam logic [CFG_DATA_W-1:0] RST_HEIGHT    = 12'd1080;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTPUT_MODE = 3'd0,
    REG_TILE_SIZE   = 3'd1,
    REG_EYE_WIDTH   = 3'd2,
    REG_EYE_HEIGHT  = 3'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_ANAGLYPH     = 2'd0,
    MODE_SIDE_BY_SIDE = 2'd1,
    MODE_TOP_BOTTOM   = 2'd2,
    MODE_CHECKER      = 2'd3
  } mode_t;

  typedef struct packed {
    logic [COLOR_W-1:0] left_red;
    logic [COLOR_W-1:0] left_green;
    logic [COLOR_W-1:0] left_blue;
    logic [COLOR_W-1:0] right_red;
    logic [COLOR_W-1:0] right_green;
    logic [COLOR_W-1:0] right_blue;
  } pix_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   out_index;
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic [COLOR_W-1:0] out_alpha;
    logic               out_last;
    logic               frame_done;
  } pix_out_t;

endpackage

/* src/sof_cfg.sv */
// Configuration registers of the stereo output formatter, size clamping and
// the registered eye-frame area. Depends on sof_pkg.
module sof_cfg #(
  parameter int MAX_EYE_WIDTH  = 2048,
  parameter int MAX_EYE_HEIGHT = 2048,
  parameter int WSW            = $clog2(MAX_EYE_WIDTH + 1),
  parameter int HSW            = $clog2(MAX_EYE_HEIGHT + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [sof_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sof_pkg::CFG_DATA_W-1:0]    cfg_data,
  output sof_pkg::mode_t                    mode,
  output logic [sof_pkg::TILE_W-1:0]        tile,
  output logic [WSW-1:0]                    width,
  output logic [HSW-1:0]                    height,
  output logic [WSW+HSW-1:0]                area
);

  logic [1:0]                      mode_r;
  logic [sof_pkg::CFG_DATA_W-1:0]  tile_r;
  logic [sof_pkg::CFG_DATA_W-1:0]  width_r;
  logic [sof_pkg::CFG_DATA_W-1:0]  height_r;
  logic [WSW+HSW-1:0]              area_r;
  logic [31:0]                     w_cl;
  logic [31:0]                     h_cl;
  logic [31:0]                     t_cl;

  always_comb begin
    if (width_r == '0) begin
      w_cl = 32'd1;
    end else if (32'(width_r) > 32'(MAX_EYE_WIDTH)) begin
      w_cl = 32'(MAX_EYE_WIDTH);
    end else begin
      w_cl = 32'(width_r);
    end
    if (height_r == '0) begin
      h_cl = 32'd1;
    end else if (32'(height_r) > 32'(MAX_EYE_HEIGHT)) begin
      h_cl = 32'(MAX_EYE_HEIGHT);
    end else begin
      h_cl = 32'(height_r);
    end
    if (tile_r == '0) begin
      t_cl = 32'd1;
    end else if (32'(tile_r) > 32'(sof_pkg::TILE_LIMIT)) begin
      t_cl = 32'(sof_pkg::TILE_LIMIT);
    end else begin
      t_cl = 32'(tile_r);
    end
  end

  assign width  = WSW'(w_cl);
  assign height = HSW'(h_cl);
  assign tile   = sof_pkg::TILE_W'(t_cl);
  assign mode   = sof_pkg::mode_t'(mode_r);
  assign area   = area_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= sof_pkg::RST_MODE;
      tile_r   <= sof_pkg::RST_TILE_SIZE;
      width_r  <= sof_pkg::RST_WIDTH;
      height_r <= sof_pkg::RST_HEIGHT;
    end else if (cfg_valid) begin
      case (sof_pkg::cfg_reg_t'(cfg_index))
        sof_pkg::REG_OUTPUT_MODE: mode_r   <= cfg_data[1:0];
        sof_pkg::REG_TILE_SIZE:   tile_r   <= cfg_data;
        sof_pkg::REG_EYE_WIDTH:   width_r  <= cfg_data;
        sof_pkg::REG_EYE_HEIGHT:  height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    area_r <= (WSW+HSW)'(width) * (WSW+HSW)'(height);
  end

endmodule

/* src/sof_position.sv */
// Raster position and checkerboard tile counters of the stereo output
// formatter. Depends on sof_pkg.
module sof_position #(
  parameter int CB  = 11,
  parameter int RB  = 11,
  parameter int WSW = 12,
  parameter int HSW = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       restart,
  input  logic                       advance,
  input  logic [WSW-1:0]             width,
  input  logic [HSW-1:0]             height,
  input  logic [sof_pkg::TILE_W-1:0] tile,
  output logic [CB-1:0]              col,
  output logic [RB-1:0]              row,
  output logic                       pick_left,
  output logic                       done
);

  logic [CB-1:0]                  col_r, col_nxt;
  logic [RB-1:0]                  row_r, row_nxt;
  logic [sof_pkg::TILE_CNT_W-1:0] cit_r, cit_nxt;
  logic [sof_pkg::TILE_CNT_W-1:0] rit_r, rit_nxt;
  logic                           cpar_r, cpar_nxt;
  logic                           rpar_r, rpar_nxt;
  logic                           end_row;
  logic                           end_ctile;
  logic                           end_rtile;

  assign end_row   = (32'(col_r) + 32'd1) >= 32'(width);
  assign done      = end_row && ((32'(row_r) + 32'd1) >= 32'(height));
  assign end_ctile = (sof_pkg::TILE_W'(cit_r) + sof_pkg::TILE_W'(1)) >= tile;
  assign end_rtile = (sof_pkg::TILE_W'(rit_r) + sof_pkg::TILE_W'(1)) >= tile;
  assign col       = col_r;
  assign row       = row_r;
  assign pick_left = (cpar_r == rpar_r);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    cit_nxt  = cit_r;
    rit_nxt  = rit_r;
    cpar_nxt = cpar_r;
    rpar_nxt = rpar_r;
    if (!end_row) begin
      col_nxt = col_r + CB'(1);
      if (end_ctile) begin
        cit_nxt  = '0;
        cpar_nxt = ~cpar_r;
      end else begin
        cit_nxt = cit_r + sof_pkg::TILE_CNT_W'(1);
      end
    end else begin
      col_nxt  = '0;
      cit_nxt  = '0;
      cpar_nxt = 1'b0;
      if (done) begin
        row_nxt  = '0;
        rit_nxt  = '0;
        rpar_nxt = 1'b0;
      end else begin
        row_nxt = row_r + RB'(1);
        if (end_rtile) begin
          rit_nxt  = '0;
          rpar_nxt = ~rpar_r;
        end else begin
          rit_nxt = rit_r + sof_pkg::TILE_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r  <= '0;
      row_r  <= '0;
      cit_r  <= '0;
      rit_r  <= '0;
      cpar_r <= 1'b0;
      rpar_r <= 1'b0;
    end else if (advance) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      cit_r  <= cit_nxt;
      rit_r  <= rit_nxt;
      cpar_r <= cpar_nxt;
      rpar_r <= rpar_nxt;
    end
  end

endmodule

/* src/sof_out.sv */
// Result register of the stereo output formatter: holds the one or two
// result beats of an input pair and sends them in order. Depends on sof_pkg.
module sof_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  sof_pkg::pix_out_t res0,
  input  sof_pkg::pix_out_t res1,
  input  logic              two,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output sof_pkg::pix_out_t out_data
);

  sof_pkg::pix_out_t res0_r;
  sof_pkg::pix_out_t res1_r;
  logic              two_r;
  logic              valid_r;
  logic              sel_r;

  assign out_valid = valid_r;
  assign out_data  = sel_r ? res1_r : res0_r;
  assign free      = !valid_r || (out_ready && (!two_r || sel_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      sel_r   <= 1'b0;
    end else if (valid_r && out_ready) begin
      if (two_r && !sel_r) begin
        sel_r <= 1'b1;
      end else begin
        valid_r <= 1'b0;
        sel_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res0_r <= res0;
      res1_r <= res1;
      two_r  <= two;
    end
  end

endmodule

/* src/stereo_output_formatter_top.sv */
// Stereo output formatter top level: input register, output formatting and
// result register. Depends on sof_pkg, sof_cfg, sof_position and sof_out.
//
// One input beat carries a left and a right pixel of the same eye-frame
// position, in raster order. Anaglyph and checkerboard modes give one result
// beat per input beat and take one input beat per cycle while out_ready is
// high; side-by-side and top-bottom give two result beats per input beat, so
// a new input beat waits in the input register until the second is sent. An
// accepted beat passes the input register, then the result register. The
// input side keeps accepting while a result waits on out_ready, up to one
// held input beat. Any configuration write, to any index, restarts the frame
// at row 0, column 0; write registers only while no beat is in flight.
module stereo_output_formatter_top #(
  parameter int MAX_EYE_WIDTH  = 2048,
  parameter int MAX_EYE_HEIGHT = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sof_pkg::pix_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sof_pkg::pix_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sof_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sof_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int WSW = $clog2(MAX_EYE_WIDTH + 1);
  localparam int HSW = $clog2(MAX_EYE_HEIGHT + 1);
  localparam int CB  = $clog2(MAX_EYE_WIDTH);
  localparam int RB  = $clog2(MAX_EYE_HEIGHT);
  localparam int IW  = WSW + HSW + 1;

  sof_pkg::mode_t             mode;
  logic [sof_pkg::TILE_W-1:0] tile;
  logic [WSW-1:0]             width;
  logic [HSW-1:0]             height;
  logic [WSW+HSW-1:0]         area;
  logic [CB-1:0]              col;
  logic [RB-1:0]              row;
  logic                       pick_left;
  logic                       done;
  logic                       in_acc;
  logic                       out_free;
  logic                       s1_move;

  logic                       s1_valid_r;
  sof_pkg::pix_in_t           s1_pix_r;
  logic [CB-1:0]              s1_col_r;
  logic [RB-1:0]              s1_row_r;
  logic                       s1_left_r;
  logic                       s1_done_r;

  logic [IW-1:0]              base;
  logic [IW-1:0]              idx0;
  logic [IW-1:0]              idx1;
  logic                       two;
  sof_pkg::pix_out_t          res0;
  sof_pkg::pix_out_t          res1;

  assign cfg_ready = 1'b1;
  assign in_ready  = !s1_valid_r || out_free;
  assign in_acc    = in_valid && in_ready;
  assign s1_move   = s1_valid_r && out_free;

  sof_cfg #(
    .MAX_EYE_WIDTH  (MAX_EYE_WIDTH),
    .MAX_EYE_HEIGHT (MAX_EYE_HEIGHT),
    .WSW            (WSW),
    .HSW            (HSW)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .tile      (tile),
    .width     (width),
    .height    (height),
    .area      (area)
  );

  sof_position #(
    .CB  (CB),
    .RB  (RB),
    .WSW (WSW),
    .HSW (HSW)
  ) u_position (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_valid),
    .advance   (in_acc),
    .width     (width),
    .height    (height),
    .tile      (tile),
    .col       (col),
    .row       (row),
    .pick_left (pick_left),
    .done      (done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_data;
      s1_col_r  <= col;
      s1_row_r  <= row;
      s1_left_r <= pick_left;
      s1_done_r <= done;
    end
  end

  always_comb begin
    base = IW'(s1_row_r) * IW'(width);
    two  = (mode == sof_pkg::MODE_SIDE_BY_SIDE) || (mode == sof_pkg::MODE_TOP_BOTTOM);
    if (mode == sof_pkg::MODE_SIDE_BY_SIDE) begin
      idx0 = (base << 1) + IW'(s1_col_r);
      idx1 = (base << 1) + IW'(width) + IW'(s1_col_r);
    end else begin
      idx0 = base + IW'(s1_col_r);
      idx1 = base + IW'(area) + IW'(s1_col_r);
    end

    res0.out_index  = sof_pkg::IDX_W'(idx0);
    res0.out_alpha  = sof_pkg::ALPHA_OPAQUE;
    res0.out_last   = !two;
    res0.frame_done = s1_done_r;
    res1.out_index  = sof_pkg::IDX_W'(idx1);
    res1.out_red    = s1_pix_r.right_red;
    res1.out_green  = s1_pix_r.right_green;
    res1.out_blue   = s1_pix_r.right_blue;
    res1.out_alpha  = sof_pkg::ALPHA_OPAQUE;
    res1.out_last   = 1'b1;
    res1.frame_done = s1_done_r;

    case (mode)
      sof_pkg::MODE_CHECKER: begin
        res0.out_red   = s1_left_r ? s1_pix_r.left_red   : s1_pix_r.right_red;
        res0.out_green = s1_left_r ? s1_pix_r.left_green : s1_pix_r.right_green;
        res0.out_blue  = s1_left_r ? s1_pix_r.left_blue  : s1_pix_r.right_blue;
      end
      sof_pkg::MODE_SIDE_BY_SIDE, sof_pkg::MODE_TOP_BOTTOM: begin
        res0.out_red   = s1_pix_r.left_red;
        res0.out_green = s1_pix_r.left_green;
        res0.out_blue  = s1_pix_r.left_blue;
      end
      default: begin
        res0.out_red   = s1_pix_r.left_red;
        res0.out_green = s1_pix_r.right_green;
        res0.out_blue  = s1_pix_r.right_blue;
      end
    endcase
  end

  sof_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_move),
    .res0      (res0),
    .res1      (res1),
    .two       (two),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for stereo_output_formatter_top: a directed table, then random
// pixel-pair beats under changing register settings, each result beat checked per field.
// Depends on sof_pkg and the formatter RTL only.
module tb_top;

  localparam int unsigned EYE_MAX = 2048;
  localparam int unsigned TILE_MAX = 2048;
  localparam logic [sof_pkg::COLOR_W-1:0] ALPHA_FULL = 8'hFF;
  localparam logic [sof_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam int TOTAL_PAIRS = 1150;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic {ROW_WRITE, ROW_PAIR} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [sof_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [sof_pkg::CFG_DATA_W-1:0] value;
    sof_pkg::pix_in_t px;
    int n_typed;
    sof_pkg::pix_out_t typed0;
    sof_pkg::pix_out_t typed1;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sof_pkg::pix_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sof_pkg::pix_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sof_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sof_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  sof_pkg::mode_t fmt_mode = sof_pkg::MODE_ANAGLYPH;
  logic [sof_pkg::CFG_DATA_W-1:0] fmt_tile = 12'd8;
  logic [sof_pkg::CFG_DATA_W-1:0] fmt_width = 12'd1920;
  logic [sof_pkg::CFG_DATA_W-1:0] fmt_height = 12'd1080;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned col_in_tile = 0;
  int unsigned row_in_tile = 0;
  bit col_parity = 1'b0;
  bit row_parity = 1'b0;

  sof_pkg::pix_out_t expected_beats[$];
  plan_row_t plan[$];
  int idle_in = 26;
  int idle_out = 77;
  int pairs_sent = 0;
  int beats_checked = 0;
  int frames_seen = 0;
  int writes_done = 0;
  int error_count = 0;
  int cycle_count = 0;

  stereo_output_formatter_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_out);
  end

  function automatic int unsigned eff_size(input logic [sof_pkg::CFG_DATA_W-1:0] v,
                                           input int unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic sof_pkg::pix_out_t make_beat(input logic [31:0] idx,
                                                  input logic [7:0] r,
                                                  input logic [7:0] g, input logic [7:0] b,
                                                  input bit last, input bit done);
    sof_pkg::pix_out_t beat;
    beat.out_index = idx[sof_pkg::IDX_W-1:0];
    beat.out_red = r;
    beat.out_green = g;
    beat.out_blue = b;
    beat.out_alpha = ALPHA_FULL;
    beat.out_last = last;
    beat.frame_done = done;
    return beat;
  endfunction

  function automatic int format_pair(input sof_pkg::pix_in_t px,
                                     output sof_pkg::pix_out_t lead,
                                     output sof_pkg::pix_out_t trail);
    int unsigned w;
    int unsigned h;
    int unsigned ts;
    bit end_row;
    bit done;
    int n;
    w = eff_size(fmt_width, EYE_MAX);
    h = eff_size(fmt_height, EYE_MAX);
    ts = eff_size(fmt_tile, TILE_MAX);
    end_row = col_pos >= w - 1;
    done = end_row && (row_pos >= h - 1);
    trail = '0;
    n = 1;
    case (fmt_mode)
      sof_pkg::MODE_SIDE_BY_SIDE: begin
        lead = make_beat(row_pos * (2 * w) + col_pos,
                         px.left_red, px.left_green, px.left_blue, 1'b0, done);
        trail = make_beat(row_pos * (2 * w) + w + col_pos,
                          px.right_red, px.right_green, px.right_blue, 1'b1, done);
        n = 2;
      end
      sof_pkg::MODE_TOP_BOTTOM: begin
        lead = make_beat(row_pos * w + col_pos,
                         px.left_red, px.left_green, px.left_blue, 1'b0, done);
        trail = make_beat((h + row_pos) * w + col_pos,
                          px.right_red, px.right_green, px.right_blue, 1'b1, done);
        n = 2;
      end
      sof_pkg::MODE_CHECKER: begin
        if (col_parity == row_parity) begin
          lead = make_beat(row_pos * w + col_pos,
                           px.left_red, px.left_green, px.left_blue, 1'b1, done);
        end else begin
          lead = make_beat(row_pos * w + col_pos,
                           px.right_red, px.right_green, px.right_blue, 1'b1, done);
        end
      end
      default: begin
        lead = make_beat(row_pos * w + col_pos,
                         px.left_red, px.right_green, px.right_blue, 1'b1, done);
      end
    endcase
    if (!end_row) begin
      col_pos++;
      if (col_in_tile >= ts - 1) begin
        col_in_tile = 0;
        col_parity = ~col_parity;
      end else begin
        col_in_tile++;
      end
    end else begin
      col_pos = 0;
      col_in_tile = 0;
      col_parity = 1'b0;
      if (done) begin
        row_pos = 0;
        row_in_tile = 0;
        row_parity = 1'b0;
      end else begin
        row_pos++;
        if (row_in_tile >= ts - 1) begin
          row_in_tile = 0;
          row_parity = ~row_parity;
        end else begin
          row_in_tile++;
        end
      end
    end
    return n;
  endfunction

  function automatic sof_pkg::pix_in_t rand_pix();
    logic [47:0] bits;
    logic [31:0] upper;
    bits[31:0] = $urandom();
    upper = $urandom();
    bits[47:32] = upper[15:0];
    return sof_pkg::pix_in_t'(bits);
  endfunction

  function automatic logic [31:0] size_extreme();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'd2047;
      3: return 32'd2048;
      4: return 32'd2049;
      default: return 32'd4095;
    endcase
  endfunction

  function automatic logic [sof_pkg::CFG_DATA_W-1:0] pick_value(
      input logic [sof_pkg::CFG_IDX_W-1:0] idx);
    logic [31:0] v;
    int unsigned roll;
    roll = $urandom_range(99);
    v = $urandom();
    case (idx)
      sof_pkg::REG_TILE_SIZE: begin
        if (roll < 60) v = $urandom_range(4, 1);
        else if (roll < 80) v = size_extreme();
        else if (roll < 90) v = $urandom_range(16, 5);
      end
      sof_pkg::REG_EYE_WIDTH: begin
        if (roll < 65) v = $urandom_range(8, 1);
        else if (roll < 85) v = size_extreme();
      end
      sof_pkg::REG_EYE_HEIGHT: begin
        if (roll < 65) v = $urandom_range(6, 1);
        else if (roll < 85) v = size_extreme();
      end
      default: ;
    endcase
    return v[sof_pkg::CFG_DATA_W-1:0];
  endfunction

  function automatic void add_write(input logic [sof_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [sof_pkg::CFG_DATA_W-1:0] value);
    plan_row_t r;
    r.kind = ROW_WRITE;
    r.reg_idx = idx;
    r.value = value;
    r.px = '0;
    r.n_typed = 0;
    r.typed0 = '0;
    r.typed1 = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_typed(input sof_pkg::pix_in_t px, input int n,
                                    input sof_pkg::pix_out_t t0,
                                    input sof_pkg::pix_out_t t1);
    plan_row_t r;
    r.kind = ROW_PAIR;
    r.reg_idx = '0;
    r.value = '0;
    r.px = px;
    r.n_typed = n;
    r.typed0 = t0;
    r.typed1 = t1;
    plan.push_back(r);
  endfunction

  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sof_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sof_pkg::CFG_DATA_W-1:0] value);
    wait_idle(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      sof_pkg::REG_OUTPUT_MODE: fmt_mode = sof_pkg::mode_t'(value[1:0]);
      sof_pkg::REG_TILE_SIZE: fmt_tile = value;
      sof_pkg::REG_EYE_WIDTH: fmt_width = value;
      sof_pkg::REG_EYE_HEIGHT: fmt_height = value;
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
    col_in_tile = 0;
    row_in_tile = 0;
    col_parity = 1'b0;
    row_parity = 1'b0;
    writes_done++;
  endtask

  task automatic send_pair(input sof_pkg::pix_in_t px, input int n_typed,
                           input sof_pkg::pix_out_t typed0,
                           input sof_pkg::pix_out_t typed1);
    sof_pkg::pix_out_t lead;
    sof_pkg::pix_out_t trail;
    int n;
    if (pairs_sent >= 2 * TOTAL_PAIRS / 3) begin
      idle_in = 0;
      idle_out = 0;
    end else if (pairs_sent >= TOTAL_PAIRS / 3) begin
      idle_in = 77;
      idle_out = 26;
    end
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (!in_ready);
    n = format_pair(px, lead, trail);
    if (n_typed > 0) begin
      lead = typed0;
      trail = typed1;
      n = n_typed;
    end
    expected_beats.push_back(lead);
    if (n == 2) expected_beats.push_back(trail);
    pairs_sent++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_beat
    sof_pkg::pix_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with none expected: index 0x%0h", out_data.out_index);
        error_count++;
      end else begin
        want = expected_beats.pop_front();
        check_field("out_index", 32'(want.out_index), 32'(out_data.out_index));
        check_field("out_red", 32'(want.out_red), 32'(out_data.out_red));
        check_field("out_green", 32'(want.out_green), 32'(out_data.out_green));
        check_field("out_blue", 32'(want.out_blue), 32'(out_data.out_blue));
        check_field("out_alpha", 32'(want.out_alpha), 32'(out_data.out_alpha));
        check_field("out_last", 32'(want.out_last), 32'(out_data.out_last));
        check_field("frame_done", 32'(want.frame_done), 32'(out_data.frame_done));
        beats_checked++;
        if (want.frame_done && want.out_last) frames_seen++;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout: %0d result beats still outstanding", expected_beats.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] roll;
    logic [sof_pkg::CFG_IDX_W-1:0] reg_idx;
    int n_writes;
    int seg_len;

    add_typed(sof_pkg::pix_in_t'{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66}, 1,
              make_beat(0, 8'h11, 8'h55, 8'h66, 1'b1, 1'b0), '0);
    add_typed(sof_pkg::pix_in_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1,
              make_beat(1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0), '0);
    add_typed(sof_pkg::pix_in_t'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1,
              make_beat(2, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0), '0);
    add_write(sof_pkg::REG_OUTPUT_MODE, {10'd0, sof_pkg::MODE_SIDE_BY_SIDE});
    add_write(sof_pkg::REG_EYE_WIDTH, 12'd0);
    add_write(sof_pkg::REG_EYE_HEIGHT, 12'd0);
    add_typed(sof_pkg::pix_in_t'{8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'hEE, 8'hFF}, 2,
              make_beat(0, 8'hAA, 8'hBB, 8'hCC, 1'b0, 1'b1),
              make_beat(1, 8'hDD, 8'hEE, 8'hFF, 1'b1, 1'b1));
    add_typed(sof_pkg::pix_in_t'{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20}, 2,
              make_beat(0, 8'h01, 8'h02, 8'h04, 1'b0, 1'b1),
              make_beat(1, 8'h08, 8'h10, 8'h20, 1'b1, 1'b1));
    add_write(sof_pkg::REG_OUTPUT_MODE, {10'd0, sof_pkg::MODE_TOP_BOTTOM});
    add_typed(sof_pkg::pix_in_t'{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00}, 2,
              make_beat(0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1),
              make_beat(1, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
    add_write(sof_pkg::REG_EYE_WIDTH, 12'd4095);
    add_write(sof_pkg::REG_EYE_HEIGHT, 12'd4095);
    add_write(sof_pkg::REG_OUTPUT_MODE, {10'd0, sof_pkg::MODE_SIDE_BY_SIDE});
    add_typed(sof_pkg::pix_in_t'{8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04}, 2,
              make_beat(0, 8'h80, 8'h40, 8'h20, 1'b0, 1'b0),
              make_beat(2048, 8'h10, 8'h08, 8'h04, 1'b1, 1'b0));
    add_typed(rand_pix(), 0, '0, '0);
    add_write(sof_pkg::REG_OUTPUT_MODE, {10'd0, sof_pkg::MODE_TOP_BOTTOM});
    add_typed(sof_pkg::pix_in_t'{8'h7F, 8'hFE, 8'h01, 8'hFE, 8'h7F, 8'h80}, 2,
              make_beat(0, 8'h7F, 8'hFE, 8'h01, 1'b0, 1'b0),
              make_beat(4194304, 8'hFE, 8'h7F, 8'h80, 1'b1, 1'b0));
    add_typed(rand_pix(), 0, '0, '0);
    add_write(sof_pkg::REG_OUTPUT_MODE, {10'd0, sof_pkg::MODE_CHECKER});
    add_write(sof_pkg::REG_TILE_SIZE, 12'd0);
    add_write(sof_pkg::REG_EYE_WIDTH, 12'd3);
    add_write(sof_pkg::REG_EYE_HEIGHT, 12'd2);
    add_typed(sof_pkg::pix_in_t'{8'h12, 8'h34, 8'h56, 8'h9A, 8'hBC, 8'hDE}, 1,
              make_beat(0, 8'h12, 8'h34, 8'h56, 1'b1, 1'b0), '0);
    repeat (6) add_typed(rand_pix(), 0, '0, '0);
    add_write(sof_pkg::REG_TILE_SIZE, 12'd4095);
    add_write(sof_pkg::REG_EYE_WIDTH, 12'd5);
    repeat (5) add_typed(rand_pix(), 0, '0, '0);
    add_write(sof_pkg::REG_TILE_SIZE, 12'd2048);
    repeat (2) add_typed(rand_pix(), 0, '0, '0);
    add_write(REG_UNUSED, 12'hFFF);
    add_typed(sof_pkg::pix_in_t'{8'hC3, 8'h3C, 8'h5A, 8'hA5, 8'h0F, 8'hF0}, 1,
              make_beat(0, 8'hC3, 8'h3C, 8'h5A, 1'b1, 1'b0), '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        send_pair(plan[i].px, plan[i].n_typed, plan[i].typed0, plan[i].typed1);
      end
    end

    while (pairs_sent < TOTAL_PAIRS) begin
      n_writes = $urandom_range(4, 1);
      repeat (n_writes) begin
        roll = ($urandom_range(15) == 0) ? $urandom_range(7, 4) : $urandom_range(3, 0);
        reg_idx = roll[sof_pkg::CFG_IDX_W-1:0];
        write_reg(reg_idx, pick_value(reg_idx));
      end
      seg_len = $urandom_range(60, 8);
      repeat (seg_len) send_pair(rand_pix(), 0, '0, '0);
    end

    wait_idle(16);
    $display("Drove %0d pixel pairs through %0d register writes in all four modes",
             pairs_sent, writes_done);
    $display("Checked %0d result beats, %0d eye frames completed", beats_checked,
             frames_seen);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
